@@ rtl/psfs_pkg.sv @@
package psfs_pkg;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT   = 3'd0,
        REG_BLOCK_IN_FRAMES = 3'd1,
        REG_NUM_SUBFILTERS  = 3'd2,
        REG_SUBFILTER_TAPS  = 3'd3,
        REG_INPUT_STEP      = 3'd4,
        REG_OUTPUT_STEP     = 3'd5,
        REG_FILTER_SHIFT    = 3'd6,
        REG_SAMPLE_FORMAT   = 3'd7
    } t_reg_idx;

    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S24 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam int COEF_FRAC_SHIFT = 23;
    localparam int COEF_DROP       = 8;
    localparam int MAX_FILTER_SHIFT = 8;
    localparam int MAX_STEP        = 16;
    localparam int MAX_BLOCK       = 16;

    localparam int ACC_W = 64;

endpackage

@@ rtl/polyphase_src_fir_stage_core.sv @@
// Polyphase FIR sample-rate converter stage. Each transfer on the input channel is either a
// coefficient write (cmd 0) or one channel sample word. A sample that does not complete a
// block passes through S_SAMPLE back to idle. A sample that completes a block starts the
// filter run: one shared 24x32 multiplier and a 64-bit accumulator walk every subfilter,
// channel and tap, one tap per cycle through a three-stage pipeline (memory read, multiply,
// accumulate), with drain states and a write-back state after each dot product and one
// setup state per subfilter, followed by num_subfilters*channel_count result transfers,
// one read of the output ring memory per word. After reset the history ring
// (HISTORY_DEPTH entries) and the output ring (OUT_DEPTH entries) are cleared one entry per
// cycle; no item is taken until the history ring is cleared. Configuration writes take effect
// at once; make them only while no block is running.
module polyphase_src_fir_stage_core #(
    parameter int MAX_CHANNELS   = 8,
    parameter int MAX_SUBFILTERS = 8,
    parameter int MAX_TAPS       = 128,
    parameter int HISTORY_DEPTH  = 2048,
    parameter int OUT_DEPTH      = 128,
    parameter int COEF_DEPTH     = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [9:0]  i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_out_sample,
    output logic        o_last
);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int OW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(COEF_DEPTH);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam int SW = $clog2(MAX_SUBFILTERS + 1);
    localparam int TOTW = NW + SW;
    localparam int ACC_W_L = psfs_pkg::ACC_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SAMPLE, S_SETUP, S_TAP, S_DRAIN1, S_DRAIN2, S_DRAIN3,
        S_WRITE, S_RD, S_RDWAIT, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [NW-1:0] r_nch;
    logic [4:0]    r_blk;
    logic [SW-1:0] r_nsf;
    logic [TW-1:0] r_taps;
    logic [4:0]    r_istep, r_ostep;
    logic [3:0]    r_fshift;
    logic [1:0]    r_fmt;

    logic signed [31:0] hist_mem [HISTORY_DEPTH];
    logic signed [31:0] out_mem  [OUT_DEPTH];
    logic signed [31:0] coef_mem [COEF_DEPTH];

    logic [HW-1:0] r_wptr;
    logic [7:0]    r_wcnt;
    logic [OW-1:0] r_rptr;
    logic [HW-1:0] r_clr;

    logic [SW-1:0] r_i;
    logic [NW-1:0] r_j;
    logic [TW-1:0] r_k;
    logic [HW-1:0] r_ha;
    logic [CW-1:0] r_ca, r_cbase;
    logic [HW-1:0] r_hbase;
    logic [OW-1:0] r_wa, r_wbase;
    logic          r_rd_v, r_mul_v;
    logic signed [31:0] r_hd, r_cd;
    logic signed [63:0] r_prod;
    logic signed [ACC_W_L-1:0] r_acc;
    logic [TOTW-1:0] r_ocnt;
    logic [TOTW-1:0] r_total;
    logic signed [31:0] r_od;

    function automatic logic [7:0] clampv(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
        clampv = (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    logic [7:0] c_ch, c_bl, c_sf, c_tp, c_is, c_os, c_fs, c_fm;
    always_comb begin
        c_ch = clampv(i_cfg_data, 8'd1, 8'(MAX_CHANNELS));
        c_bl = clampv(i_cfg_data, 8'd1, 8'(psfs_pkg::MAX_BLOCK));
        c_sf = clampv(i_cfg_data, 8'd1, 8'(MAX_SUBFILTERS));
        c_tp = (i_cfg_data < 8'd1) ? 8'd1 :
               ((32'(i_cfg_data) > MAX_TAPS) ? 8'(MAX_TAPS) : i_cfg_data);
        c_is = clampv(i_cfg_data, 8'd1, 8'(psfs_pkg::MAX_STEP));
        c_os = clampv(i_cfg_data, 8'd1, 8'(psfs_pkg::MAX_STEP));
        c_fs = clampv(i_cfg_data, 8'd0, 8'(psfs_pkg::MAX_FILTER_SHIFT));
        c_fm = clampv(i_cfg_data, 8'd0, 8'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch <= NW'(2); r_blk <= 5'd1; r_nsf <= SW'(1); r_taps <= TW'(16);
            r_istep <= 5'd1; r_ostep <= 5'd1; r_fshift <= 4'd0; r_fmt <= psfs_pkg::FMT_S32;
        end else if (i_cfg_we) begin
            case (psfs_pkg::t_reg_idx'(i_cfg_idx))
                psfs_pkg::REG_CHANNEL_COUNT:   r_nch    <= NW'(c_ch);
                psfs_pkg::REG_BLOCK_IN_FRAMES: r_blk    <= 5'(c_bl);
                psfs_pkg::REG_NUM_SUBFILTERS:  r_nsf    <= SW'(c_sf);
                psfs_pkg::REG_SUBFILTER_TAPS:  r_taps   <= TW'(c_tp);
                psfs_pkg::REG_INPUT_STEP:      r_istep  <= 5'(c_is);
                psfs_pkg::REG_OUTPUT_STEP:     r_ostep  <= 5'(c_os);
                psfs_pkg::REG_FILTER_SHIFT:    r_fshift <= 4'(c_fs);
                psfs_pkg::REG_SAMPLE_FORMAT:   r_fmt    <= 2'(c_fm);
                default: ;
            endcase
        end
    end

    logic in_xfer;
    assign o_ready = (r_state == S_IDLE);
    assign in_xfer = i_valid && o_ready;

    logic signed [31:0] scaled_in;
    always_comb begin
        case (r_fmt)
            psfs_pkg::FMT_S16: scaled_in = {i_sample[15:0], 16'd0};
            psfs_pkg::FMT_S24: scaled_in = {i_sample[23:0], 8'd0};
            default:           scaled_in = i_sample;
        endcase
    end

    // memories
    logic          hist_we;
    logic [HW-1:0] hist_wa;
    logic signed [31:0] hist_wd;
    assign hist_we = (r_state == S_CLEAR) || (in_xfer && i_cmd == psfs_pkg::CMD_SAMPLE);
    assign hist_wa = (r_state == S_CLEAR) ? r_clr : r_wptr;
    assign hist_wd = (r_state == S_CLEAR) ? 32'sd0 : scaled_in;

    logic signed [31:0] sat_res;
    logic          out_we;
    logic [OW-1:0] out_wa;
    assign out_we = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign out_wa = (r_state == S_CLEAR) ? OW'(r_clr) : r_wa;

    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[hist_wa] <= hist_wd;
        r_hd <= hist_mem[r_ha];
    end
    always_ff @(posedge i_clk) begin
        if (out_we) out_mem[out_wa] <= (r_state == S_CLEAR) ? 32'sd0 : sat_res;
        r_od <= out_mem[r_rptr];
    end
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_cmd == psfs_pkg::CMD_COEF && 32'(i_coef_index) < COEF_DEPTH)
            coef_mem[CW'(i_coef_index)] <= i_coef_value;
        r_cd <= coef_mem[r_ca];
    end

    // rounding and saturation of the accumulator
    logic [5:0] q;
    logic signed [ACC_W_L-1:0] shifted;
    assign q = 6'(psfs_pkg::COEF_FRAC_SHIFT) + 6'(r_fshift);
    assign shifted = r_acc >>> q;
    assign sat_res = (shifted > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (shifted < -64'sh80000000) ? 32'sh80000000 : shifted[31:0];

    // output format scaling
    logic signed [32:0] r16;
    logic signed [31:0] scaled_out;
    always_comb begin
        r16 = 33'((r_od >>> 15) + 32'sd1) >>> 1;
        case (r_fmt)
            psfs_pkg::FMT_S16:
                scaled_out = (r16 > 33'sd32767) ? 32'sd32767 :
                             (r16 < -33'sd32768) ? -32'sd32768 : r16[31:0];
            psfs_pkg::FMT_S24: scaled_out = r_od >>> 8;
            default:           scaled_out = r_od;
        endcase
    end

    // address arithmetic for the next subfilter
    logic [15:0] frames_i;
    logic [HW-1:0] hbase_i;
    logic [CW-1:0] cbase_i;
    logic [OW-1:0] wbase_i;
    always_comb begin
        frames_i = 16'(r_blk) + 16'(r_nsf - SW'(1) - r_i) * 16'(r_istep);
        hbase_i  = r_wptr + HW'(32'(frames_i) * 32'(r_nch));
        cbase_i  = CW'(32'(r_i) * 32'(r_taps));
        wbase_i  = r_rptr + OW'(32'(r_i) * 32'(r_nch) * 32'(r_ostep));
    end

    logic [8:0] wcnt_n;
    assign wcnt_n = 9'(r_wcnt) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_wptr  <= HW'(HISTORY_DEPTH - 1);
            r_wcnt  <= '0;
            r_rptr  <= '0;
            o_valid <= 1'b0;
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_mul_v <= r_rd_v;
            r_prod  <= (r_cd >>> psfs_pkg::COEF_DROP) * r_hd;
            if (r_mul_v) r_acc <= r_acc + r_prod;
            r_rd_v  <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + HW'(1);
                    if (r_clr == HW'(HISTORY_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer && i_cmd == psfs_pkg::CMD_SAMPLE) begin
                        r_wptr  <= r_wptr - HW'(1);
                        r_wcnt  <= wcnt_n[7:0];
                        r_state <= S_SAMPLE;
                    end
                end
                S_SAMPLE: begin
                    if (16'(r_wcnt) < 16'(r_nch) * 16'(r_blk)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_wcnt  <= '0;
                        r_i     <= '0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_hbase <= hbase_i;
                    r_ha    <= hbase_i;
                    r_cbase <= cbase_i;
                    r_ca    <= cbase_i;
                    r_wbase <= wbase_i;
                    r_wa    <= wbase_i;
                    r_j     <= '0;
                    r_k     <= '0;
                    r_acc   <= ACC_W_L'(1) << (q - 6'd1);
                    r_state <= S_TAP;
                end
                S_TAP: begin
                    r_rd_v <= 1'b1;
                    r_ha   <= r_ha + HW'(r_nch);
                    r_ca   <= r_ca + CW'(1);
                    r_k    <= r_k + TW'(1);
                    if (r_k == r_taps - TW'(1)) r_state <= S_DRAIN1;
                end
                S_DRAIN1: r_state <= S_DRAIN2;
                S_DRAIN2: r_state <= S_DRAIN3;
                S_DRAIN3: r_state <= S_WRITE;
                S_WRITE: begin
                    r_wa  <= r_wa + OW'(1);
                    r_k   <= '0;
                    r_ca  <= r_cbase;
                    r_ha  <= r_hbase - HW'(r_j) - HW'(1);
                    r_acc <= ACC_W_L'(1) << (q - 6'd1);
                    if (r_j == r_nch - NW'(1)) begin
                        r_j <= '0;
                        if (r_i == r_nsf - SW'(1)) begin
                            r_ocnt  <= '0;
                            r_total <= TOTW'(r_nch) * TOTW'(r_nsf);
                            r_state <= S_RD;
                        end else begin
                            r_i     <= r_i + SW'(1);
                            r_state <= S_SETUP;
                        end
                    end else begin
                        r_j     <= r_j + NW'(1);
                        r_state <= S_TAP;
                    end
                end
                S_RD: r_state <= S_RDWAIT;
                S_RDWAIT: begin
                    o_valid      <= 1'b1;
                    o_out_sample <= scaled_out;
                    o_last       <= (r_ocnt == r_total - TOTW'(1));
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_rptr  <= r_rptr + OW'(1);
                        r_ocnt  <= r_ocnt + TOTW'(1);
                        r_state <= (r_ocnt == r_total - TOTW'(1)) ? S_IDLE : S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
module tb;

    localparam int HIST_N = 2048;
    localparam int RING_N = 128;
    localparam int COEF_N = 1024;
    localparam int WDOG_LIMIT = 40000;
    localparam int NUM_PHASES = 10;

    typedef struct {
        logic        cmd;
        logic [9:0]  ci;
        logic [31:0] cv;
        logic [31:0] smp;
        bit          lit_en;
        logic [31:0] lit;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = psfs_pkg::CMD_SAMPLE;
    logic [9:0]  i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic signed [31:0] i_sample = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_out_sample;
    logic        o_last;

    polyphase_src_fir_stage_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int unsigned cfg [8];
    int unsigned reg_lo [8] = '{1, 1, 1, 1, 1, 1, 0, 0};
    int unsigned reg_hi [8] = '{8, 16, 8, 128, 16, 16, 8, 2};
    logic signed [31:0] hist [HIST_N];
    logic signed [31:0] ring [RING_N];
    logic signed [31:0] coefs [COEF_N];
    bit          coef_set [COEF_N];
    int unsigned hist_wptr;
    int unsigned word_cnt;
    int unsigned ring_rptr;

    logic [31:0] want_sample [$];
    logic        want_last [$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          stall_cycles = 0;

    function automatic logic signed [31:0] scale_to_q31(logic [31:0] w);
        case (cfg[psfs_pkg::REG_SAMPLE_FORMAT][1:0])
            psfs_pkg::FMT_S16: return {w[15:0], 16'h0};
            psfs_pkg::FMT_S24: return {w[23:0], 8'h0};
            default: return w;
        endcase
    endfunction

    function automatic logic [31:0] scale_from_q31(logic signed [31:0] x);
        longint v;
        case (cfg[psfs_pkg::REG_SAMPLE_FORMAT][1:0])
            psfs_pkg::FMT_S16: begin
                v = ((longint'(x) >>> 15) + 1) >>> 1;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 32'(v);
            end
            psfs_pkg::FMT_S24: return x >>> 8;
            default: return x;
        endcase
    endfunction

    task automatic filter_block();
        int unsigned nch, base, wbase, ha, ca, q;
        longint acc, c;
        nch = cfg[psfs_pkg::REG_CHANNEL_COUNT];
        q = psfs_pkg::COEF_FRAC_SHIFT + cfg[psfs_pkg::REG_FILTER_SHIFT];
        for (int unsigned i = 0; i < cfg[psfs_pkg::REG_NUM_SUBFILTERS]; i++) begin
            base = hist_wptr + nch * (cfg[psfs_pkg::REG_BLOCK_IN_FRAMES] +
                   (cfg[psfs_pkg::REG_NUM_SUBFILTERS] - 1 - i) * cfg[psfs_pkg::REG_INPUT_STEP]);
            wbase = ring_rptr + i * nch * cfg[psfs_pkg::REG_OUTPUT_STEP];
            for (int unsigned j = 0; j < nch; j++) begin
                acc = longint'(1) <<< (q - 1);
                for (int unsigned k = 0; k < cfg[psfs_pkg::REG_SUBFILTER_TAPS]; k++) begin
                    ha = (base + k * nch + HIST_N - j) % HIST_N;
                    ca = (i * cfg[psfs_pkg::REG_SUBFILTER_TAPS] + k) % COEF_N;
                    c = longint'(coefs[ca]) >>> psfs_pkg::COEF_DROP;
                    acc += c * longint'(hist[ha]);
                end
                acc = acc >>> q;
                if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
                if (acc < -64'sh80000000) acc = -64'sh80000000;
                ring[(wbase + j) % RING_N] = 32'(acc);
            end
        end
    endtask

    task automatic src_accept(logic cmd, logic [9:0] ci, logic [31:0] cv, logic [31:0] smp);
        int unsigned total;
        if (cmd == psfs_pkg::CMD_COEF) begin
            coefs[ci] = cv;
            coef_set[ci] = 1'b1;
        end else begin
            hist[hist_wptr] = scale_to_q31(smp);
            hist_wptr = (hist_wptr + HIST_N - 1) % HIST_N;
            word_cnt = (word_cnt + 1) & 8'hFF;
            if (word_cnt >= cfg[psfs_pkg::REG_CHANNEL_COUNT] *
                            cfg[psfs_pkg::REG_BLOCK_IN_FRAMES]) begin
                word_cnt = 0;
                filter_block();
                total = cfg[psfs_pkg::REG_CHANNEL_COUNT] * cfg[psfs_pkg::REG_NUM_SUBFILTERS];
                for (int unsigned w = 0; w < total; w++) begin
                    want_sample.push_back(scale_from_q31(ring[ring_rptr]));
                    want_last.push_back(w + 1 == total);
                    ring_rptr = (ring_rptr + 1) % RING_N;
                end
            end
        end
    endtask

    task automatic send_item(logic cmd, logic [9:0] ci, logic [31:0] cv, logic [31:0] smp,
                             bit lit_en, logic [31:0] lit);
        int before_n;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_coef_index <= ci;
        i_coef_value <= cv;
        i_sample <= smp;
        do @(posedge i_clk); while (!o_ready);
        before_n = want_sample.size();
        src_accept(cmd, ci, cv, smp);
        if (lit_en)
            for (int n = before_n; n < want_sample.size(); n++) want_sample[n] = lit;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (want_sample.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic load_config(int p);
        logic [7:0] raw [8];
        for (int r = 0; r < 8; r++)
            raw[r] = 8'($urandom_range(reg_lo[r], reg_hi[r]));
        raw[psfs_pkg::REG_BLOCK_IN_FRAMES] = 8'($urandom_range(1, 3));
        raw[psfs_pkg::REG_SUBFILTER_TAPS] = 8'($urandom_range(1, 5));
        if (p == 1) begin
            raw = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        end else if (p == 2) begin
            raw = '{8'd8, 8'd1, 8'd8, 8'd4, 8'd16, 8'd16, 8'd8, 8'd1};
        end else if (p == 3) begin
            raw = '{8'd1, 8'd255, 8'd255, 8'd4, 8'd255, 8'd255, 8'd255, 8'd3};
        end
        for (int r = 0; r < 8; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(r);
            i_cfg_data <= raw[r];
            @(posedge i_clk);
            cfg[r] = (raw[r] < reg_lo[r]) ? reg_lo[r] :
                     (raw[r] > reg_hi[r]) ? reg_hi[r] : raw[r];
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample();
        logic [31:0] edges [6] = '{32'h7FFFFFFF, 32'h80000000, 32'h00007FFF,
                                   32'hFFFF8000, 32'h007FFFFF, 32'hFF800000};
        if ($urandom_range(7) == 0) return edges[$urandom_range(5)];
        return $urandom;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (want_sample.size() == 0) begin
                $display("%0t: unexpected transfer out_sample=%h last=%b",
                         $time, o_out_sample, o_last);
                errors++;
            end else begin
                if (o_out_sample !== want_sample[0] || o_last !== want_last[0]) begin
                    $display("%0t: mismatch expected out_sample=%h last=%b actual %h %b",
                             $time, want_sample[0], want_last[0], o_out_sample, o_last);
                    errors++;
                end
                void'(want_sample.pop_front());
                void'(want_last.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_stim_row rows [12];
        int unsigned need, n_items;
        rows = '{
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h7FFFFFFF, 1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h80000000, 1'b1, 32'h0},
            '{psfs_pkg::CMD_COEF,   10'd0,    32'h80000000, 32'h0,        1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h80000000, 1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h80000000, 1'b1, 32'h7FFFFFFF},
            '{psfs_pkg::CMD_COEF,   10'd0,    32'h7FFFFFFF, 32'h0,        1'b0, 32'h0},
            '{psfs_pkg::CMD_COEF,   10'd15,   32'h12345678, 32'h0,        1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h80000000, 1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h7FFFFFFF, 1'b0, 32'h0},
            '{psfs_pkg::CMD_COEF,   10'd1023, 32'h7FFFFFFF, 32'h0,        1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'h00000000, 1'b0, 32'h0},
            '{psfs_pkg::CMD_SAMPLE, 10'd0,    32'h0,        32'hFFFFFFFF, 1'b0, 32'h0}
        };
        cfg = '{2, 1, 1, 16, 1, 1, 0, psfs_pkg::FMT_S32};
        foreach (hist[n]) hist[n] = '0;
        foreach (ring[n]) ring[n] = '0;
        foreach (coefs[n]) begin
            coefs[n] = '0;
            coef_set[n] = 1'b0;
        end
        hist_wptr = HIST_N - 1;
        word_cnt = 0;
        ring_rptr = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle = (p < 4) ? 23 : (p < 7) ? 66 : 0;
            recv_idle = (p < 4) ? 66 : (p < 7) ? 23 : 0;
            if (p > 0) load_config(p);
            need = cfg[psfs_pkg::REG_NUM_SUBFILTERS] * cfg[psfs_pkg::REG_SUBFILTER_TAPS];
            for (int unsigned ci = 0; ci < need; ci++)
                if (!coef_set[ci])
                    send_item(psfs_pkg::CMD_COEF, 10'(ci),
                              (p == 0) ? 32'h0 : $signed($urandom) >>> $urandom_range(0, 12),
                              32'h0, 1'b0, 32'h0);
            if (p == 0) begin
                foreach (rows[r])
                    send_item(rows[r].cmd, rows[r].ci, rows[r].cv, rows[r].smp,
                              rows[r].lit_en, rows[r].lit);
            end else begin
                n_items = (p == 2) ? 16 : (p == 3) ? 24 : $urandom_range(8, 12);
                for (int unsigned n = 0; n < n_items; n++)
                    if ($urandom_range(9) == 0)
                        send_item(psfs_pkg::CMD_COEF, 10'($urandom_range(COEF_N - 1)),
                                  $signed($urandom) >>> $urandom_range(0, 12),
                                  32'h0, 1'b0, 32'h0);
                    else
                        send_item(psfs_pkg::CMD_SAMPLE, 10'($urandom), $urandom,
                                  pick_sample(), 1'b0, 32'h0);
            end
            settle();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
